// File: rtl/cgm_pkg.sv
`timescale 1ns / 1ps

package cgm_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam int LVL_W = 16;
    localparam int FRAC_W = 16;
    localparam int PROD_W = LVL_W + FRAC_W;
    localparam int FRAC_SHIFT = 15;

    localparam logic [LVL_W-1:0] Q_ONE = 16'd32768;

    localparam int DEFAULT_COUNT = 7;
    localparam int LOAD_COUNT = (DEFAULT_COUNT < MAX_POINTS) ? DEFAULT_COUNT : MAX_POINTS;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [LVL_W-1:0] blue;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] pos;
    } point_t;

    // Black, blue, cyan, green, yellow, red, white.
    function automatic point_t default_point(input logic [2:0] sel);
        point_t pt;
        pt = '0;
        case (sel)
            3'd0: pt = '{blue: 16'd0, green: 16'd0, red: 16'd0, pos: 16'd0};
            3'd1: pt = '{blue: Q_ONE, green: 16'd0, red: 16'd0, pos: 16'd1638};
            3'd2: pt = '{blue: Q_ONE, green: Q_ONE, red: 16'd0, pos: 16'd9830};
            3'd3: pt = '{blue: 16'd0, green: Q_ONE, red: 16'd0, pos: 16'd18022};
            3'd4: pt = '{blue: 16'd0, green: Q_ONE, red: Q_ONE, pos: 16'd24576};
            3'd5: pt = '{blue: 16'd0, green: 16'd0, red: Q_ONE, pos: 16'd27853};
            3'd6: pt = '{blue: Q_ONE, green: Q_ONE, red: Q_ONE, pos: Q_ONE};
            default: pt = '0;
        endcase
        return pt;
    endfunction

endpackage

// File: rtl/cgm_div.sv
`timescale 1ns / 1ps

module cgm_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cgm_pkg::LVL_W-1:0]    num,
    input  logic [cgm_pkg::LVL_W-1:0]    den,
    output logic                         done,
    output logic [cgm_pkg::FRAC_W-1:0]   quo
);

    localparam int CNT_W = $clog2(cgm_pkg::FRAC_W);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [cgm_pkg::LVL_W:0]       rem_reg, rem_next;
    logic [cgm_pkg::FRAC_W-1:0]    quo_reg, quo_next;
    logic [cgm_pkg::LVL_W-1:0]     den_reg, den_next;
    logic [cgm_pkg::LVL_W:0]       shifted;
    logic [cgm_pkg::LVL_W:0]       den_ext;

    // The numerator never exceeds the divisor, so the top quotient bit is
    // taken from the unshifted remainder and every later bit after one shift.
    always_comb begin
        run_next = run_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        den_ext = {1'b0, den_reg};
        shifted = (cnt_reg == '0) ? rem_reg : {rem_reg[cgm_pkg::LVL_W-1:0], 1'b0};
        if (start) begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = {1'b0, num};
            den_next = den;
        end else if (run_reg) begin
            if (shifted >= den_ext) begin
                rem_next = shifted - den_ext;
                quo_next = {quo_reg[cgm_pkg::FRAC_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[cgm_pkg::FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(cgm_pkg::FRAC_W - 1)) begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo = quo_reg;

endmodule

// File: rtl/color_gradient_map.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   func, position, red_in, green_in, blue_in
// m_        out        m_valid / m_ready   red_out, green_out, blue_out, status
//
// One word is processed at a time; s_ready is high only while the sequencer is idle.
// Lookup walks the table entries in order and, when it interpolates, then runs the
// serial divider and the shared multiplier for red, green and blue in turn.
// Insert moves every entry past the new position up by one. Load default writes the
// seven default points.
// Reset is synchronous and empties the table. A finished word waits in the output
// register while the next word is taken; the sequencer holds when that register is full.

module color_gradient_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_position,
    input  logic [15:0] s_red_in,
    input  logic [15:0] s_green_in,
    input  logic [15:0] s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red_out,
    output logic [15:0] m_green_out,
    output logic [15:0] m_blue_out,
    output logic [1:0]  m_status
);

    localparam int IW = cgm_pkg::IDX_W;
    localparam int CW = cgm_pkg::CNT_W;
    localparam int LW = cgm_pkg::LVL_W;
    localparam int FS = cgm_pkg::FRAC_SHIFT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_DIV = 3'd2;
    localparam logic [2:0] S_MUL = 3'd3;
    localparam logic [2:0] S_INS = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;
    localparam logic [2:0] S_FIN = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   idx_inc;
    logic [LW-1:0]                   pos_reg, pos_next;
    cgm_pkg::point_t                 new_reg, new_next;
    cgm_pkg::point_t                 prev_reg, prev_next;
    cgm_pkg::point_t                 cur_reg, cur_next;
    logic [cgm_pkg::FRAC_W-1:0]      frac_reg, frac_next;
    logic [1:0]                      step_reg, step_next;
    logic [cgm_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic                            neg_reg, neg_next;
    logic [LW-1:0]                   base_reg, base_next;
    logic [LW-1:0]                   res_r_reg, res_r_next;
    logic [LW-1:0]                   res_g_reg, res_g_next;
    logic [LW-1:0]                   res_b_reg, res_b_next;
    logic [1:0]                      res_st_reg, res_st_next;
    logic                            m_valid_reg, m_valid_next;
    logic [LW-1:0]                   m_red_reg, m_red_next;
    logic [LW-1:0]                   m_green_reg, m_green_next;
    logic [LW-1:0]                   m_blue_reg, m_blue_next;
    logic [1:0]                      m_status_reg, m_status_next;

    cgm_pkg::point_t                 mem [cgm_pkg::MAX_POINTS];
    cgm_pkg::point_t                 rd_data_reg;
    logic [IW-1:0]                   rd_addr;
    logic                            wr_en;
    logic [IW-1:0]                   wr_addr;
    cgm_pkg::point_t                 wr_data;

    logic                            div_start;
    logic [LW-1:0]                   div_num;
    logic [LW-1:0]                   div_den;
    logic                            div_done;
    logic [cgm_pkg::FRAC_W-1:0]      div_quo;

    logic [LW-1:0]                   sel_prev_c;
    logic [LW-1:0]                   sel_cur_c;
    logic [LW-1:0]                   mag;
    logic [LW:0]                     part;
    logic [LW:0]                     blended;
    logic                            s_fire;

    cgm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire = s_valid && s_ready;
    assign idx_inc = idx_reg + CW'(1);

    // Color lane for the shared multiplier, picked by the step counter.
    always_comb begin
        case (step_reg)
            2'd0: begin
                sel_prev_c = prev_reg.red;
                sel_cur_c = cur_reg.red;
            end
            2'd1: begin
                sel_prev_c = prev_reg.green;
                sel_cur_c = cur_reg.green;
            end
            2'd2: begin
                sel_prev_c = prev_reg.blue;
                sel_cur_c = cur_reg.blue;
            end
            default: begin
                sel_prev_c = '0;
                sel_cur_c = '0;
            end
        endcase
        mag = (sel_prev_c < sel_cur_c) ? (sel_cur_c - sel_prev_c) : (sel_prev_c - sel_cur_c);
        part = prod_reg[cgm_pkg::PROD_W-1:FS];
        blended = neg_reg ? ({1'b0, base_reg} - part) : ({1'b0, base_reg} + part);
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        new_next = new_reg;
        prev_next = prev_reg;
        cur_next = cur_reg;
        frac_next = frac_reg;
        step_next = step_reg;
        prod_next = prod_reg;
        neg_next = neg_reg;
        base_next = base_reg;
        res_r_next = res_r_reg;
        res_g_next = res_g_reg;
        res_b_next = res_b_reg;
        res_st_next = res_st_reg;
        m_valid_next = m_valid_reg;
        m_red_next = m_red_reg;
        m_green_next = m_green_reg;
        m_blue_next = m_blue_reg;
        m_status_next = m_status_reg;
        rd_addr = idx_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = new_reg;
        div_start = 1'b0;
        div_num = rd_data_reg.pos - pos_reg;
        div_den = rd_data_reg.pos - prev_reg.pos;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    pos_next = s_position;
                    new_next = '{blue: s_blue_in, green: s_green_in, red: s_red_in,
                                 pos: s_position};
                    res_r_next = '0;
                    res_g_next = '0;
                    res_b_next = '0;
                    res_st_next = cgm_pkg::STATUS_OK;
                    idx_next = '0;
                    rd_addr = '0;
                    case (s_func)
                        cgm_pkg::FUNC_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_st_next = cgm_pkg::STATUS_EMPTY;
                                state_next = S_FIN;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        cgm_pkg::FUNC_INSERT: begin
                            if (count_reg >= CW'(cgm_pkg::MAX_POINTS)) begin
                                res_st_next = cgm_pkg::STATUS_FULL;
                                state_next = S_FIN;
                            end else begin
                                idx_next = count_reg;
                                rd_addr = IW'(count_reg - CW'(1));
                                state_next = S_INS;
                            end
                        end
                        cgm_pkg::FUNC_LOAD: begin
                            state_next = S_LOAD;
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // rd_data_reg holds the entry at idx_reg; one entry per cycle.
            S_WALK: begin
                if (pos_reg < rd_data_reg.pos) begin
                    if (idx_reg == '0) begin
                        res_r_next = rd_data_reg.red;
                        res_g_next = rd_data_reg.green;
                        res_b_next = rd_data_reg.blue;
                        state_next = S_FIN;
                    end else begin
                        cur_next = rd_data_reg;
                        div_start = 1'b1;
                        state_next = S_DIV;
                    end
                end else begin
                    prev_next = rd_data_reg;
                    if (idx_inc == count_reg) begin
                        res_r_next = rd_data_reg.red;
                        res_g_next = rd_data_reg.green;
                        res_b_next = rd_data_reg.blue;
                        state_next = S_FIN;
                    end else begin
                        idx_next = idx_inc;
                        rd_addr = idx_inc[IW-1:0];
                    end
                end
            end

            S_DIV: begin
                if (div_done) begin
                    frac_next = div_quo;
                    step_next = '0;
                    state_next = S_MUL;
                end
            end

            // Product for one color is registered, then added on the next step.
            S_MUL: begin
                if (step_reg != 2'd3) begin
                    prod_next = cgm_pkg::PROD_W'(mag) * cgm_pkg::PROD_W'(frac_reg);
                    neg_next = (sel_prev_c < sel_cur_c);
                    base_next = sel_cur_c;
                end
                case (step_reg)
                    2'd1: res_r_next = blended[LW-1:0];
                    2'd2: res_g_next = blended[LW-1:0];
                    2'd3: res_b_next = blended[LW-1:0];
                    default: ;
                endcase
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = S_FIN;
                end
            end

            // Walk down from the top, moving up every entry past the new position.
            S_INS: begin
                wr_en = 1'b1;
                if (idx_reg != '0 && rd_data_reg.pos > pos_reg) begin
                    wr_data = rd_data_reg;
                    idx_next = idx_reg - CW'(1);
                    rd_addr = IW'(idx_reg - CW'(2));
                end else begin
                    wr_data = new_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_FIN;
                end
            end

            S_LOAD: begin
                wr_en = 1'b1;
                wr_data = cgm_pkg::default_point(idx_reg[2:0]);
                idx_next = idx_inc;
                if (idx_inc == CW'(cgm_pkg::LOAD_COUNT)) begin
                    count_next = CW'(cgm_pkg::LOAD_COUNT);
                    state_next = S_FIN;
                end
            end

            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_red_next = res_r_reg;
                    m_green_next = res_g_reg;
                    m_blue_next = res_b_reg;
                    m_status_next = res_st_reg;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            step_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            step_reg <= step_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg <= pos_next;
        new_reg <= new_next;
        prev_reg <= prev_next;
        cur_reg <= cur_next;
        frac_reg <= frac_next;
        prod_reg <= prod_next;
        neg_reg <= neg_next;
        base_reg <= base_next;
        res_r_reg <= res_r_next;
        res_g_reg <= res_g_next;
        res_b_reg <= res_b_next;
        res_st_reg <= res_st_next;
        m_red_reg <= m_red_next;
        m_green_reg <= m_green_next;
        m_blue_reg <= m_blue_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid = m_valid_reg;
    assign m_red_out = m_red_reg;
    assign m_green_out = m_green_reg;
    assign m_blue_out = m_blue_reg;
    assign m_status = m_status_reg;

endmodule

// File: tb/tb_color_gradient_map.sv
`timescale 1ns / 1ps

module tb_color_gradient_map;

    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam logic [15:0] ONE_Q15 = cgm_pkg::Q_ONE;
    localparam int RANDOM_WORDS = 900;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [1:0]  st;
    } color_word_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] pos;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        typed;
        color_word_t want;
    } script_row_t;

    localparam color_word_t ZERO_OK = '{16'd0, 16'd0, 16'd0, cgm_pkg::STATUS_OK};
    localparam color_word_t BLACK = '{16'd0, 16'd0, 16'd0, cgm_pkg::STATUS_OK};
    localparam color_word_t YELLOW = '{ONE_Q15, ONE_Q15, 16'd0, cgm_pkg::STATUS_OK};
    localparam color_word_t WHITE = '{ONE_Q15, ONE_Q15, ONE_Q15, cgm_pkg::STATUS_OK};
    localparam color_word_t EMPTY_ERR = '{16'd0, 16'd0, 16'd0, cgm_pkg::STATUS_EMPTY};
    localparam color_word_t FULL_ERR = '{16'd0, 16'd0, 16'd0, cgm_pkg::STATUS_FULL};
    localparam color_word_t FIRST_PT = '{ONE_Q15, 16'd0, 16'd16384, cgm_pkg::STATUS_OK};
    localparam color_word_t SECOND_PT = '{16'd0, ONE_Q15, 16'd4660, cgm_pkg::STATUS_OK};

    // Rows with typed = 0 are checked against the predictor only.
    localparam script_row_t SCRIPT [27] = '{
        '{cgm_pkg::FUNC_LOOKUP, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, EMPTY_ERR},
        '{FUNC_NOP,             ONE_Q15,   ONE_Q15,   ONE_Q15,   ONE_Q15,   1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd16384, ONE_Q15,   16'd0,     16'd16384, 1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd16384, 16'd0,     ONE_Q15,   16'd4660,  1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_LOOKUP, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, FIRST_PT},
        '{cgm_pkg::FUNC_LOOKUP, 16'd16384, 16'd0,     16'd0,     16'd0,     1'b1, SECOND_PT},
        '{cgm_pkg::FUNC_LOOKUP, ONE_Q15,   16'd0,     16'd0,     16'd0,     1'b1, SECOND_PT},
        '{cgm_pkg::FUNC_INSERT, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_LOOKUP, 16'd8191,  16'd0,     16'd0,     16'd0,     1'b0, ZERO_OK},
        '{cgm_pkg::FUNC_LOOKUP, 16'd16383, 16'd0,     16'd0,     16'd0,     1'b0, ZERO_OK},
        '{cgm_pkg::FUNC_LOAD,   16'd0,     16'd0,     16'd0,     16'd0,     1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_LOOKUP, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, BLACK},
        '{cgm_pkg::FUNC_LOOKUP, 16'd24576, 16'd0,     16'd0,     16'd0,     1'b1, YELLOW},
        '{cgm_pkg::FUNC_LOOKUP, ONE_Q15,   16'd0,     16'd0,     16'd0,     1'b1, WHITE},
        '{cgm_pkg::FUNC_LOOKUP, 16'd1000,  16'd0,     16'd0,     16'd0,     1'b0, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, ONE_Q15,   16'd32767, 16'd0,     ONE_Q15,   1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, ONE_Q15,   16'd0,     16'd32767, 16'd21845, 1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd0,     ONE_Q15,   ONE_Q15,   ONE_Q15,   1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd21845, 16'd10922, 16'd32767, 16'd0,     1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd1638,  16'd1,     16'd2,     16'd3,     1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd12288, ONE_Q15,   16'd0,     16'd32767, 1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd32767, 16'd21845, 16'd10922, 16'd32767, 1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd27000, 16'd0,     ONE_Q15,   16'd1,     1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd5000,  16'd32000, 16'd100,   ONE_Q15,   1'b1, ZERO_OK},
        '{cgm_pkg::FUNC_INSERT, 16'd100,   ONE_Q15,   ONE_Q15,   ONE_Q15,   1'b1, FULL_ERR},
        '{cgm_pkg::FUNC_LOOKUP, 16'd20000, 16'd0,     16'd0,     16'd0,     1'b0, ZERO_OK},
        '{cgm_pkg::FUNC_LOOKUP, 16'd32767, 16'd0,     16'd0,     16'd0,     1'b0, ZERO_OK}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = cgm_pkg::FUNC_LOOKUP;
    logic [15:0] s_position = '0;
    logic [15:0] s_red_in = '0;
    logic [15:0] s_green_in = '0;
    logic [15:0] s_blue_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_red_out;
    logic [15:0] m_green_out;
    logic [15:0] m_blue_out;
    logic [1:0]  m_status;

    // Predictor state: a sorted copy of the color point table.
    cgm_pkg::point_t map_pts [cgm_pkg::MAX_POINTS];
    int unsigned     map_count = 0;

    color_word_t expected_colors [$];
    int          mismatches = 0;
    int          burst_left = 0;
    logic [31:0] rx_cyc = '0;
    logic [1:0]  rx_mode = 2'd0;

    color_gradient_map dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_position  (s_position),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_status    (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The product is truncated toward zero, so negative deltas round up.
    function automatic logic [15:0] mix_level(input logic [15:0] prev_lvl,
                                              input logic [15:0] cur_lvl,
                                              input int unsigned frac);
        longint delta;
        longint prod;
        longint part;
        delta = longint'(prev_lvl) - longint'(cur_lvl);
        prod = delta * longint'(frac);
        if (prod < 0) begin
            part = -((-prod) >>> 15);
        end else begin
            part = prod >>> 15;
        end
        return 16'(longint'(cur_lvl) + part);
    endfunction

    function automatic color_word_t predict_color(input logic [1:0] func,
                                                  input logic [15:0] pos,
                                                  input logic [15:0] red,
                                                  input logic [15:0] green,
                                                  input logic [15:0] blue);
        color_word_t res;
        int unsigned at;
        int unsigned span;
        int unsigned frac;
        bit found;
        cgm_pkg::point_t cur;
        cgm_pkg::point_t prv;
        res = ZERO_OK;
        found = 1'b0;
        case (func)
            cgm_pkg::FUNC_LOOKUP: begin
                if (map_count == 0) begin
                    res.st = cgm_pkg::STATUS_EMPTY;
                end else begin
                    for (int i = 0; i < map_count; i++) begin
                        if (!found && pos < map_pts[i].pos) begin
                            found = 1'b1;
                            cur = map_pts[i];
                            if (i == 0) begin
                                res.red = cur.red;
                                res.green = cur.green;
                                res.blue = cur.blue;
                            end else begin
                                prv = map_pts[i-1];
                                span = cur.pos - prv.pos;
                                frac = ((int'(cur.pos) - int'(pos)) << 15) / span;
                                res.red = mix_level(prv.red, cur.red, frac);
                                res.green = mix_level(prv.green, cur.green, frac);
                                res.blue = mix_level(prv.blue, cur.blue, frac);
                            end
                        end
                    end
                    if (!found) begin
                        res.red = map_pts[map_count-1].red;
                        res.green = map_pts[map_count-1].green;
                        res.blue = map_pts[map_count-1].blue;
                    end
                end
            end
            cgm_pkg::FUNC_INSERT: begin
                if (map_count >= cgm_pkg::MAX_POINTS) begin
                    res.st = cgm_pkg::STATUS_FULL;
                end else begin
                    at = map_count;
                    for (int i = map_count - 1; i >= 0; i--) begin
                        if (map_pts[i].pos > pos) begin
                            at = i;
                        end
                    end
                    for (int i = map_count; i > at; i--) begin
                        map_pts[i] = map_pts[i-1];
                    end
                    map_pts[at] = '{blue: blue, green: green, red: red, pos: pos};
                    map_count++;
                end
            end
            cgm_pkg::FUNC_LOAD: begin
                // Black, blue, cyan, green, yellow, red and white.
                map_pts[0] = '{blue: 16'd0, green: 16'd0, red: 16'd0, pos: 16'd0};
                map_pts[1] = '{blue: ONE_Q15, green: 16'd0, red: 16'd0, pos: 16'd1638};
                map_pts[2] = '{blue: ONE_Q15, green: ONE_Q15, red: 16'd0, pos: 16'd9830};
                map_pts[3] = '{blue: 16'd0, green: ONE_Q15, red: 16'd0, pos: 16'd18022};
                map_pts[4] = '{blue: 16'd0, green: ONE_Q15, red: ONE_Q15, pos: 16'd24576};
                map_pts[5] = '{blue: 16'd0, green: 16'd0, red: ONE_Q15, pos: 16'd27853};
                map_pts[6] = '{blue: ONE_Q15, green: ONE_Q15, red: ONE_Q15, pos: ONE_Q15};
                map_count = 7;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return ONE_Q15;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Favors stored positions and their neighbors, where the search turns over.
    function automatic logic [15:0] pick_position();
        logic [15:0] q;
        q = 16'($urandom_range(0, 32768));
        if (map_count > 0) begin
            case ($urandom_range(0, 9))
                0: q = $urandom_range(0, 1) ? ONE_Q15 : 16'd0;
                1, 2: q = map_pts[$urandom_range(0, map_count - 1)].pos;
                3: begin
                    q = map_pts[$urandom_range(0, map_count - 1)].pos;
                    if (q > 16'd0 && $urandom_range(0, 1)) begin
                        q = q - 16'd1;
                    end else if (q < ONE_Q15) begin
                        q = q + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_word(input logic [1:0] func, input logic [15:0] pos,
                             input logic [15:0] red, input logic [15:0] green,
                             input logic [15:0] blue, input logic typed,
                             input color_word_t want);
        color_word_t calc;
        int gap;
        s_valid <= 1'b1;
        s_func <= func;
        s_position <= pos;
        s_red_in <= red;
        s_green_in <= green;
        s_blue_in <= blue;
        do @(posedge aclk); while (!s_ready);
        calc = predict_color(func, pos, red, green, blue);
        expected_colors.insert(expected_colors.size(), typed ? want : calc);
        burst_left--;
        if (burst_left <= 0) begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Result side: check each word taken, then pick the next ready value.
    always @(posedge aclk) begin
        color_word_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending, status %0d",
                                          m_status));
            end else begin
                exp_word = expected_colors.pop_front();
                if (m_red_out !== exp_word.red)
                    report_mismatch($sformatf("red got %0d expected %0d",
                                              m_red_out, exp_word.red));
                if (m_green_out !== exp_word.green)
                    report_mismatch($sformatf("green got %0d expected %0d",
                                              m_green_out, exp_word.green));
                if (m_blue_out !== exp_word.blue)
                    report_mismatch($sformatf("blue got %0d expected %0d",
                                              m_blue_out, exp_word.blue));
                if (m_status !== exp_word.st)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              m_status, exp_word.st));
            end
        end
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc[7:0] == 8'd0) begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        case (rx_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= (rx_cyc[1:0] != 2'd3);
            2'd2: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (rx_cyc[3:0] >= 4'd11);
        endcase
    end

    initial begin
        int sel;
        logic [1:0] func;
        logic [15:0] pos;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(1, 16);

        foreach (SCRIPT[i]) begin
            send_word(SCRIPT[i].func, SCRIPT[i].pos, SCRIPT[i].red, SCRIPT[i].green,
                      SCRIPT[i].blue, SCRIPT[i].typed, SCRIPT[i].want);
        end

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 7) begin
                func = cgm_pkg::FUNC_LOAD;
            end else if (sel < 30) begin
                func = cgm_pkg::FUNC_INSERT;
            end else if (sel < 33) begin
                func = FUNC_NOP;
            end else begin
                func = cgm_pkg::FUNC_LOOKUP;
            end
            pos = pick_position();
            send_word(func, pos, pick_level(), pick_level(), pick_level(), 1'b0, ZERO_OK);
        end
        s_valid <= 1'b0;

        while (expected_colors.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS color_gradient_map");
        end else begin
            $display("FAIL color_gradient_map");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL color_gradient_map");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cgm_pkg.sv
rtl/cgm_div.sv
rtl/color_gradient_map.sv
tb/tb_color_gradient_map.sv
